/* sv/ansi_escape_stream_parser_core_macros.svh */
// Assertion macros for the escape stream parser core
`ifndef ANSI_ESCAPE_STREAM_PARSER_CORE_MACROS_SVH
`define ANSI_ESCAPE_STREAM_PARSER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AESP_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("parser check failed");
`define AESP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("parser check failed");
`else
`define AESP_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define AESP_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* sv/aesp_pkg.sv */
// Types and codes shared by the escape stream parser
package aesp_pkg;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_STYLE  = 3'd3;
    localparam logic [2:0] ACT_SHOW   = 3'd4;

    localparam logic [1:0] WGT_KEEP   = 2'd0;
    localparam logic [1:0] WGT_NORMAL = 2'd1;
    localparam logic [1:0] WGT_BOLD   = 2'd2;

    localparam logic [2:0] COL_KEEP    = 3'd0;
    localparam logic [2:0] COL_BLACK   = 3'd1;
    localparam logic [2:0] COL_RED     = 3'd2;
    localparam logic [2:0] COL_GREEN   = 3'd3;
    localparam logic [2:0] COL_YELLOW  = 3'd4;
    localparam logic [2:0] COL_BLUE    = 3'd5;
    localparam logic [2:0] COL_MAGENTA = 3'd6;
    localparam logic [2:0] COL_CYAN    = 3'd7;

    // SGR parameter values understood by the final 'm'
    localparam logic [7:0] SGR_RESET   = 8'd0;
    localparam logic [7:0] SGR_BOLD    = 8'd1;
    localparam logic [7:0] SGR_BLACK   = 8'd30;
    localparam logic [7:0] SGR_RED     = 8'd31;
    localparam logic [7:0] SGR_GREEN   = 8'd32;
    localparam logic [7:0] SGR_YELLOW  = 8'd33;
    localparam logic [7:0] SGR_BLUE    = 8'd34;
    localparam logic [7:0] SGR_MAGENTA = 8'd35;
    localparam logic [7:0] SGR_CYAN    = 8'd36;
    localparam logic [7:0] SGR_WHITE   = 8'd37;
    localparam logic [7:0] SGR_DEFAULT = 8'd39;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CSI   = 8'h9B;
    localparam logic [7:0] CH_OSC   = 8'h9D;
    localparam logic [7:0] CH_SHY   = 8'hAD;

    localparam logic [2:0] CFG_IDX_PARSE = 3'd0;

    typedef struct packed {
        logic       in_escape;
        logic       in_csi;
        logic       in_osc;
        logic       after_separator;
        logic       second_present;
        logic [7:0] second_value;
    } seq_state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [7:0]        out_char;
        logic signed [7:0] shown_code;
        logic [1:0]        weight_change;
        logic [2:0]        color_change;
    } result_t;

endpackage

/* sv/aesp_step.sv */
// Per-character next-state and result logic of the escape parser
module aesp_step (
    input  logic [7:0]          char_code,
    input  logic                parse_escapes,
    input  aesp_pkg::seq_state_t cur,
    output aesp_pkg::seq_state_t nxt,
    output aesp_pkg::result_t   res
);

    logic [7:0]  final_code;
    logic [3:0]  digit;
    logic [11:0] acc_wide;
    logic        is_digit;
    logic        printable;

    assign is_digit = char_code inside {[8'h30:8'h39]};
    assign digit    = 4'(char_code - 8'h30);
    // value*10 + digit, up to 2550 + 9
    assign acc_wide = ({4'b0, cur.second_value} << 3) + ({4'b0, cur.second_value} << 1)
                    + {8'b0, digit};
    assign printable = (char_code inside {[8'h20:8'h7E]})
                    || ((char_code inside {[8'hA0:8'hFF]}) && (char_code != aesp_pkg::CH_SHY));

    always_comb
    begin
        nxt        = cur;
        res        = '0;
        final_code = aesp_pkg::CH_NUL;
        if (cur.in_escape)
        begin
            if (cur.in_csi || cur.in_osc)
            begin
                if (is_digit)
                begin
                    if (cur.after_separator)
                    begin
                        if (!cur.second_present)
                            nxt.second_value = {4'b0, digit};
                        else if (acc_wide > 12'd255)
                            nxt.second_value = 8'hFF;
                        else
                            nxt.second_value = acc_wide[7:0];
                        nxt.second_present = 1'b1;
                    end
                end
                else if (char_code == aesp_pkg::CH_SEMI)
                    nxt.after_separator = 1'b1;
                else if (cur.in_osc)
                begin
                    if (char_code == aesp_pkg::CH_BEL)
                        final_code = char_code;
                end
                else
                    final_code = char_code;
            end
            else if (char_code == aesp_pkg::CH_LBRK)
                nxt.in_csi = 1'b1;
            else if (char_code == aesp_pkg::CH_RBRK)
                nxt.in_osc = 1'b1;
            else if (char_code != aesp_pkg::CH_LPAR && char_code != aesp_pkg::CH_RPAR)
                final_code = char_code;

            if (final_code != aesp_pkg::CH_NUL)
            begin
                if (final_code == aesp_pkg::CH_M)
                begin
                    res.action = aesp_pkg::ACT_STYLE;
                    if (!cur.second_present)
                        res.color_change = aesp_pkg::COL_BLACK;
                    else
                    begin
                        case (cur.second_value)
                            aesp_pkg::SGR_RESET:
                            begin
                                res.weight_change = aesp_pkg::WGT_NORMAL;
                                res.color_change  = aesp_pkg::COL_BLACK;
                            end
                            aesp_pkg::SGR_BOLD:    res.weight_change = aesp_pkg::WGT_BOLD;
                            aesp_pkg::SGR_RED:     res.color_change  = aesp_pkg::COL_RED;
                            aesp_pkg::SGR_GREEN:   res.color_change  = aesp_pkg::COL_GREEN;
                            aesp_pkg::SGR_YELLOW:  res.color_change  = aesp_pkg::COL_YELLOW;
                            aesp_pkg::SGR_BLUE:    res.color_change  = aesp_pkg::COL_BLUE;
                            aesp_pkg::SGR_MAGENTA: res.color_change  = aesp_pkg::COL_MAGENTA;
                            aesp_pkg::SGR_CYAN:    res.color_change  = aesp_pkg::COL_CYAN;
                            aesp_pkg::SGR_BLACK, aesp_pkg::SGR_WHITE, aesp_pkg::SGR_DEFAULT:
                                res.color_change = aesp_pkg::COL_BLACK;
                            default: res.color_change = aesp_pkg::COL_KEEP;
                        endcase
                    end
                end
                nxt = '0;
            end
        end
        else if (char_code == aesp_pkg::CH_CR)
        begin
            res.action   = aesp_pkg::ACT_INSERT;
            res.out_char = aesp_pkg::CH_LF;
        end
        else if (printable || char_code == aesp_pkg::CH_LF)
        begin
            res.action   = aesp_pkg::ACT_INSERT;
            res.out_char = char_code;
        end
        else if (parse_escapes)
        begin
            if (char_code == aesp_pkg::CH_DEL || char_code == aesp_pkg::CH_BS)
                res.action = aesp_pkg::ACT_DELETE;
            else if (char_code == aesp_pkg::CH_ESC)
                nxt.in_escape = 1'b1;
            else if (char_code == aesp_pkg::CH_CSI)
            begin
                nxt.in_escape = 1'b1;
                nxt.in_csi    = 1'b1;
            end
            else if (char_code == aesp_pkg::CH_OSC)
            begin
                nxt.in_escape = 1'b1;
                nxt.in_osc    = 1'b1;
            end
        end
        else if (char_code != aesp_pkg::CH_NUL)
        begin
            res.action     = aesp_pkg::ACT_SHOW;
            res.shown_code = signed'(char_code);
        end
    end

endmodule

/* sv/ansi_escape_stream_parser_core.sv */
// Escape stream parser core: character register, parse step, result register.
// Each transferred character is held in the character register; its result is
// registered in the result register once that register is free.
// Throughput: one character per cycle unless result_stall holds; the result
// register lets the next character enter while a finished result is still stalled.
// Reset: all sequence state cleared, parse_escapes set to 1, both stages empty.
`include "ansi_escape_stream_parser_core_macros.svh"
module ansi_escape_stream_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              char_valid,
    output logic              char_stall,
    input  logic [7:0]        char_code,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [2:0]        action,
    output logic [7:0]        out_char,
    output logic signed [7:0] shown_code,
    output logic [1:0]        weight_change,
    output logic [2:0]        color_change
);

    logic                 parse_reg;
    logic                 parse_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [7:0]           s1_char_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    aesp_pkg::result_t    out_reg;
    aesp_pkg::seq_state_t seq_reg;
    aesp_pkg::seq_state_t seq_step;
    aesp_pkg::result_t    res_step;
    logic                 out_free;
    logic                 s1_adv;
    logic                 in_xfer;
    logic                 cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready
                   && (paddr[2] == aesp_pkg::CFG_IDX_PARSE[0]);
    assign prdata   = (paddr[2] == aesp_pkg::CFG_IDX_PARSE[0]) ? {31'b0, parse_reg} : 32'b0;
    assign parse_next = cfg_wr ? pwdata[0] : parse_reg;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && out_free;
    assign char_stall = s1_valid_reg && !out_free;
    assign in_xfer    = char_valid && !char_stall;

    assign s1_valid_next  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    aesp_step u_step (
        .char_code     (s1_char_reg),
        .parse_escapes (parse_reg),
        .cur           (seq_reg),
        .nxt           (seq_step),
        .res           (res_step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg     <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
        end
        else
        begin
            parse_reg     <= parse_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                seq_reg <= seq_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_char_reg <= char_code;
        if (s1_adv)
            out_reg <= res_step;
    end

    assign result_valid  = out_valid_reg;
    assign action        = out_reg.action;
    assign out_char      = out_reg.out_char;
    assign shown_code    = out_reg.shown_code;
    assign weight_change = out_reg.weight_change;
    assign color_change  = out_reg.color_change;

    `AESP_ASSERT_SAME(a_seq_nested, clk, rst_n, !seq_reg.in_escape,
        !seq_reg.in_csi && !seq_reg.in_osc && !seq_reg.second_present)
    `AESP_ASSERT_SAME(a_style_only, clk, rst_n,
        result_valid && action != aesp_pkg::ACT_STYLE,
        weight_change == aesp_pkg::WGT_KEEP && color_change == aesp_pkg::COL_KEEP)
    `AESP_ASSERT_SAME(a_char_only, clk, rst_n,
        result_valid && action != aesp_pkg::ACT_INSERT, out_char == 8'd0)
    `AESP_ASSERT_NEXT(a_advance, clk, rst_n, s1_valid_reg && out_free, result_valid)

endmodule
